[src/lzw_decoder_16bit_codes_macros.svh]
// Assertion macros used by the LZW decoder datapath
`ifndef LZW_DECODER_16BIT_CODES_MACROS_SVH
`define LZW_DECODER_16BIT_CODES_MACROS_SVH
// Check that a condition holds at every edge outside reset
`define LZWD_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("lzwd16 check failed");
// Check that a condition at one edge implies another at the next edge
`define LZWD_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("lzwd16 check failed");
`endif

[src/lzwd16_pkg.sv]
// Shared constants, types and state encoding for the LZW decoder
package lzwd16_pkg;
    localparam int DICT_ENTRIES_DEF   = 65278;
    localparam int MAX_STRING_LEN_DEF = 64;

    localparam logic [15:0] CODE_CLEAR  = 16'hFFFE;
    localparam logic [15:0] CODE_END    = 16'hFFFF;
    localparam logic [15:0] LITERAL_TOP = 16'd255;
    localparam logic [15:0] DICT_BASE   = 16'd256;

    localparam logic [1:0] ST_DATA = 2'd0;
    localparam logic [1:0] ST_END  = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;
    localparam logic [1:0] ST_LONG = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK,
        S_PUSH,
        S_POPRD,
        S_POPLD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic       latch;
        logic       clear;
        logic       halt;
        logic       load_stat;
        logic       start;
        logic       rd_dict;
        logic       push_mem;
        logic       push_lit;
        logic       rd_stack;
        logic       load_data;
    } t_cmd;

    typedef struct packed {
        logic       halted;
        logic       clear;
        logic       stop;
        logic [1:0] st;
        logic       last;
        logic       cur_lit;
    } t_stat;
endpackage

[src/lzwd16_ctrl.sv]
// Sequencer for the LZW decoder: decode, chain walk and byte output
module lzwd16_ctrl import lzwd16_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state r_state;
    t_state n_state;

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // advance and issue commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.halted) begin
                    n_state = S_IDLE;
                end else if (i_stat.clear) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_IDLE;
                end else if (i_stat.stop) begin
                    o_cmd.halt      = 1'b1;
                    o_cmd.load_stat = 1'b1;
                    n_state         = S_OUT;
                end else begin
                    o_cmd.start = 1'b1;
                    n_state     = S_WALK;
                end
            end
            S_WALK: begin
                if (i_stat.cur_lit) begin
                    o_cmd.push_lit = 1'b1;
                    n_state        = S_POPRD;
                end else begin
                    o_cmd.rd_dict = 1'b1;
                    n_state       = S_PUSH;
                end
            end
            S_PUSH: begin
                o_cmd.push_mem = 1'b1;
                n_state        = S_WALK;
            end
            S_POPRD: begin
                o_cmd.rd_stack = 1'b1;
                n_state        = S_POPLD;
            end
            S_POPLD: begin
                o_cmd.load_data = 1'b1;
                n_state         = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = i_stat.last ? S_IDLE : S_POPRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

[src/lzwd16_dp.sv]
// Datapath for the LZW decoder: dictionary, reverse stack and state registers
module lzwd16_dp import lzwd16_pkg::*; #(
    parameter int DICT_ENTRIES   = DICT_ENTRIES_DEF,
    parameter int MAX_STRING_LEN = MAX_STRING_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_code,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic [7:0]  o_data_byte,
    output logic        o_last_of_run,
    output logic [1:0]  o_status
);
`include "lzw_decoder_16bit_codes_macros.svh"

    localparam int AW  = $clog2(DICT_ENTRIES);
    localparam int SAW = $clog2(MAX_STRING_LEN);
    localparam int SCW = $clog2(MAX_STRING_LEN + 1);
    localparam logic [16:0] TOP_CODE = 17'(int'(LITERAL_TOP) + DICT_ENTRIES);

    logic [15:0]    r_code;
    logic [15:0]    r_hc;
    logic [15:0]    r_prev;
    logic           r_havep;
    logic           r_halted;
    logic [SCW-1:0] r_prev_len;
    logic [7:0]     r_prev_first;
    logic           r_pend;
    logic [15:0]    r_cur;
    logic [SCW-1:0] r_sp;
    logic [23:0]    r_dict [DICT_ENTRIES];
    logic [23:0]    r_dict_q;
    logic [7:0]     r_stack [MAX_STRING_LEN];
    logic [7:0]     r_stack_q;
    logic [7:0]     r_data;
    logic           r_last;
    logic [1:0]     r_status;

    logic [16:0]    hc1;
    logic           full;
    logic           is_bad;
    logic           add;
    logic           kwk;
    logic           too_long;
    logic [AW-1:0]  slot;
    logic [AW-1:0]  rd_addr;
    logic           wr_en;
    logic [7:0]     wr_tail;
    logic           push;
    logic [7:0]     push_byte;

    // classify the latched code
    always_comb begin
        hc1      = {1'b0, r_hc} + 17'd1;
        full     = {1'b0, r_hc} >= TOP_CODE;
        kwk      = {1'b0, r_code} == hc1;
        is_bad   = ({1'b0, r_code} > hc1) || (kwk && (!r_havep || full));
        add      = r_havep && !full;
        too_long = add && (r_prev_len >= SCW'(MAX_STRING_LEN));
        slot     = AW'(r_hc - LITERAL_TOP);
        rd_addr  = AW'(r_cur - DICT_BASE);
        wr_en    = (i_cmd.start && add && kwk) || (i_cmd.push_lit && r_pend);
        wr_tail  = i_cmd.start ? r_prev_first : r_cur[7:0];
        push     = i_cmd.push_mem || i_cmd.push_lit;
        push_byte = i_cmd.push_mem ? r_dict_q[7:0] : r_cur[7:0];

        o_stat.halted  = r_halted;
        o_stat.clear   = r_code == CODE_CLEAR;
        o_stat.stop    = (r_code == CODE_END) || is_bad || too_long;
        o_stat.st      = (r_code == CODE_END) ? ST_END : (is_bad ? ST_BAD : ST_LONG);
        o_stat.last    = r_last;
        o_stat.cur_lit = r_cur <= LITERAL_TOP;
    end

    // dictionary memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_dict[slot] <= {r_prev, wr_tail};
        end
        if (i_cmd.rd_dict) begin
            r_dict_q <= r_dict[rd_addr];
        end
    end

    // reverse stack memory
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_stack[r_sp[SAW-1:0]] <= push_byte;
        end
        if (i_cmd.rd_stack) begin
            r_stack_q <= r_stack[SAW'(r_sp - SCW'(1))];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hc         <= LITERAL_TOP;
            r_prev       <= '0;
            r_havep      <= 1'b0;
            r_halted     <= 1'b0;
            r_pend       <= 1'b0;
            r_sp         <= '0;
            r_prev_len   <= '0;
            r_prev_first <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_hc    <= LITERAL_TOP;
                r_havep <= 1'b0;
                r_prev  <= '0;
            end
            if (i_cmd.halt) begin
                r_halted <= 1'b1;
            end
            if (wr_en) begin
                r_hc <= r_hc + 16'd1;
            end
            if (i_cmd.start) begin
                r_sp   <= '0;
                r_pend <= add && !kwk;
            end
            if (push) begin
                r_sp <= r_sp + SCW'(1);
            end
            if (i_cmd.push_lit) begin
                r_prev_len   <= r_sp + SCW'(1);
                r_prev_first <= r_cur[7:0];
                r_prev       <= r_code;
                r_havep      <= 1'b1;
                r_pend       <= 1'b0;
            end
            if (i_cmd.load_data) begin
                r_sp <= r_sp - SCW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_code <= i_code;
        end
        if (i_cmd.start) begin
            r_cur <= r_code;
        end else if (i_cmd.push_mem) begin
            r_cur <= r_dict_q[23:8];
        end
        if (i_cmd.load_stat) begin
            r_data   <= '0;
            r_last   <= 1'b1;
            r_status <= o_stat.st;
        end else if (i_cmd.load_data) begin
            r_data   <= r_stack_q;
            r_last   <= r_sp == SCW'(1);
            r_status <= ST_DATA;
        end
    end

    assign o_data_byte   = r_data;
    assign o_last_of_run = r_last;
    assign o_status      = r_status;

    `LZWD_ASSERT_ALWAYS(a_hc_bound, {1'b0, r_hc} <= TOP_CODE)
    `LZWD_ASSERT_ALWAYS(a_sp_bound, r_sp <= SCW'(MAX_STRING_LEN))
    `LZWD_ASSERT_NEXT(a_halt_sticky, r_halted, r_halted)
endmodule

[src/lzw_decoder_16bit_codes.sv]
// LZW decoder for fixed 16-bit codes: each code expands to its bytes, at most one new entry per code.
// A code is latched on acceptance and decoded in DECIDE; the prefix chain walk reads and pushes
// each dictionary step (WALK, PUSH), then the closing literal; each byte is then popped (POPRD,
// POPLD) and held in OUT until taken. A new code is accepted only after the last output is taken.
// Clear and halted codes return to idle; end and error results give one status output first.
// Reset (synchronous, active low) empties the dictionary by count; no clearing pass is needed.
module lzw_decoder_16bit_codes import lzwd16_pkg::*; #(
    parameter int DICT_ENTRIES   = DICT_ENTRIES_DEF,
    parameter int MAX_STRING_LEN = MAX_STRING_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_code,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_data_byte,
    output logic        o_last_of_run,
    output logic [1:0]  o_status
);
    t_cmd  cmd;
    t_stat stat;

    lzwd16_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lzwd16_dp #(
        .DICT_ENTRIES   (DICT_ENTRIES),
        .MAX_STRING_LEN (MAX_STRING_LEN)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_code        (i_code),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_data_byte   (o_data_byte),
        .o_last_of_run (o_last_of_run),
        .o_status      (o_status)
    );
endmodule
